[hdl/ocv_pkg.sv]
// Shared types, constants and helper functions of the orbit camera view unit.
// No dependencies; every other file imports this package.
package ocv_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int ROW_W      = 3;
  localparam int VAL_W      = 32;
  localparam int UVAL_W     = 31;
  localparam int MUL_OP_W   = 33;
  localparam int MUL_ACC_W  = 68;
  localparam int CORDIC_W   = 34;
  localparam int ATAN_IDX_W = 5;

  // Top bit of the radian-to-turn product that lands in the angle register.
  localparam int ANGLE_FRAC_TOP = 47;

  localparam logic signed [VAL_W-1:0]    ONE_Q16     = 32'sh0001_0000;
  localparam logic signed [MUL_OP_W-1:0] RAD_TO_TURN = 33'sd683565276;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] CORDIC_RND  = 34'sd8192;

  localparam logic [UVAL_W-1:0] SENS_RESET  = 31'd65536;
  localparam logic [UVAL_W-1:0] MIN_RESET   = 31'd0;
  localparam logic [UVAL_W-1:0] MAX_RESET   = 31'd655360;
  localparam logic [UVAL_W-1:0] START_RESET = 31'd327680;

  typedef enum logic [OP_W-1:0] {
    OP_ROTATE = 2'd0,
    OP_ZOOM   = 2'd1,
    OP_FRAME  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSITIVITY = 3'd0,
    CFG_MIN_DIST    = 3'd1,
    CFG_MAX_DIST    = 3'd2,
    CFG_START_DIST  = 3'd3,
    CFG_TARGET_X    = 3'd4,
    CFG_TARGET_Y    = 3'd5,
    CFG_TARGET_Z    = 3'd6
  } cfg_idx_e;

  typedef enum logic [ROW_W-1:0] {
    ROW_COL0 = 3'd0,
    ROW_COL1 = 3'd1,
    ROW_COL2 = 3'd2,
    ROW_COL3 = 3'd3,
    ROW_POS  = 3'd4
  } row_e;

  typedef struct packed {
    logic start;
    logic accum;
  } mul_cmd_t;

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic [31:0] ocv_atan(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic signed [VAL_W-1:0] ocv_sat_wide(
    input logic signed [MUL_ACC_W-1:0] v
  );
    logic fits;
    fits = (&v[MUL_ACC_W-1:VAL_W-1]) || !(|v[MUL_ACC_W-1:VAL_W-1]);
    if (fits) return v[VAL_W-1:0];
    return v[MUL_ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [VAL_W-1:0] ocv_sat33(input logic signed [VAL_W:0] v);
    if (v[VAL_W] == v[VAL_W-1]) return v[VAL_W-1:0];
    return v[VAL_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [VAL_W:0] ocv_sext33(input logic [VAL_W-1:0] v);
    return {v[VAL_W-1], v};
  endfunction

  // Clamp to [lo, max(lo, hi)].
  function automatic logic signed [VAL_W-1:0] ocv_clamp(
    input logic signed [VAL_W-1:0] v,
    input logic [UVAL_W-1:0]       lo,
    input logic [UVAL_W-1:0]       hi
  );
    logic signed [VAL_W-1:0] lo_s;
    logic signed [VAL_W-1:0] hi_s;
    lo_s = {1'b0, lo};
    hi_s = (hi < lo) ? {1'b0, lo} : {1'b0, hi};
    if (v < lo_s) return lo_s;
    if (v > hi_s) return hi_s;
    return v;
  endfunction

endpackage

[hdl/ocv_if.sv]
// Handshake channels of the orbit camera view unit: item in, row out, register write.
// Depends on ocv_pkg for field widths.
interface ocv_item_if import ocv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [VAL_W-1:0] delta_x;
  logic signed [VAL_W-1:0] delta_y;
  logic signed [VAL_W-1:0] delta_distance;
  logic [UVAL_W-1:0]       time_step;

  modport source (output valid, operation, delta_x, delta_y, delta_distance, time_step,
                  input ready);
  modport sink (input valid, operation, delta_x, delta_y, delta_distance, time_step,
                output ready);
endinterface

interface ocv_row_if import ocv_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        row_index;
  logic signed [VAL_W-1:0] value_0;
  logic signed [VAL_W-1:0] value_1;
  logic signed [VAL_W-1:0] value_2;
  logic signed [VAL_W-1:0] value_3;
  logic                    last_row;

  modport source (output valid, row_index, value_0, value_1, value_2, value_3, last_row,
                  input ready);
  modport sink (input valid, row_index, value_0, value_1, value_2, value_3, last_row,
                output ready);
endinterface

interface ocv_cfg_if import ocv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/ocv_serial_mul.sv]
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on ocv_pkg.
module ocv_serial_mul import ocv_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mul_cmd_t                    cmd_i,
  input  logic signed [MUL_OP_W-1:0]  a_i,
  input  logic signed [MUL_OP_W-1:0]  b_i,
  output logic                        done_o,
  output logic signed [MUL_ACC_W-1:0] acc_o
);

  localparam int CntW = $clog2(MUL_OP_W + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic signed [MUL_ACC_W-1:0] mcand_q;
  logic [MUL_OP_W-1:0]         mplier_q;
  logic signed [MUL_ACC_W-1:0] acc_q;
  logic                        sign_bit;

  assign sign_bit = (cnt_q == CntW'(MUL_OP_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (sign_bit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q  <= {{(MUL_ACC_W-MUL_OP_W){a_i[MUL_OP_W-1]}}, a_i};
      mplier_q <= b_i;
      if (!cmd_i.accum) acc_q <= '0;
    end else if (busy_q) begin
      // top multiplier bit carries negative weight
      if (mplier_q[0]) acc_q <= sign_bit ? acc_q - mcand_q : acc_q + mcand_q;
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> busy_q)
    else $error("multiplier not busy after start");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q) && !busy_q)
    else $error("multiplier done without a run");

endmodule

[hdl/ocv_cordic.sv]
// Iterative CORDIC in rotation mode: cosine and sine of a turn-fraction angle, Q16.16.
// Depends on ocv_pkg for the arctangent table and constants.
module ocv_cordic import ocv_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [ANGLE_BITS-1:0]   angle_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] cos_o,
  output logic signed [VAL_W-1:0] sin_o
);

  localparam int IterW = $clog2(CORDIC_STEPS + 1);

  logic                       busy_q;
  logic                       done_q;
  logic [IterW-1:0]           iter_q;
  logic                       flip_q;
  logic signed [CORDIC_W-1:0] x_q;
  logic signed [CORDIC_W-1:0] y_q;
  logic signed [CORDIC_W-1:0] z_q;

  logic [31:0]                turn;
  logic                       flip;
  logic [31:0]                turn_f;
  logic signed [CORDIC_W-1:0] z_init;
  logic signed [CORDIC_W-1:0] atan_v;
  logic signed [CORDIC_W-1:0] xr;
  logic signed [CORDIC_W-1:0] yr;
  logic signed [CORDIC_W-1:0] xo;
  logic signed [CORDIC_W-1:0] yo;
  logic                       last_iter;

  // Fold the left half-plane onto the right one and negate the results.
  assign turn      = {angle_i, {(32-ANGLE_BITS){1'b0}}};
  assign flip      = turn[31] ^ turn[30];
  assign turn_f    = {turn[31] ^ flip, turn[30:0]};
  assign z_init    = {{(CORDIC_W-32){turn_f[31]}}, turn_f};
  assign atan_v    = {{(CORDIC_W-32){1'b0}}, ocv_atan(ATAN_IDX_W'(iter_q))};
  assign last_iter = (iter_q == IterW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + IterW'(1);
        if (last_iter) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= z_init;
      flip_q <= flip;
    end else if (busy_q) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - (y_q >>> iter_q);
        y_q <= y_q + (x_q >>> iter_q);
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + (y_q >>> iter_q);
        y_q <= y_q - (x_q >>> iter_q);
        z_q <= z_q + atan_v;
      end
    end
  end

  // Round Q30 to Q16.16
  assign xr    = (x_q + CORDIC_RND) >>> 14;
  assign yr    = (y_q + CORDIC_RND) >>> 14;
  assign xo    = flip_q ? -xr : xr;
  assign yo    = flip_q ? -yr : yr;
  assign cos_o = xo[VAL_W-1:0];
  assign sin_o = yo[VAL_W-1:0];
  assign done_o = done_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q) && !busy_q)
    else $error("cordic done without a run");

endmodule

[hdl/orbit_camera_view_update_unit.sv]
// Orbit camera view unit: sequencer, state registers and writeback around a shared
// bit-serial multiplier and an iterative CORDIC. Depends on ocv_pkg, ocv_if,
// ocv_serial_mul and ocv_cordic.
//
// Usage: items arrive on item_i (valid/ready); a beat is taken only when the unit is
// idle. Rotate and zoom items change the angles or the distance and give no output.
// A frame item gives five beats on row_o: view matrix columns 0 to 3, then the camera
// position, flagged by last_row. Registers are written on cfg_i (always ready) and
// should only be written while the unit is idle.
// Timing: every product goes through the one-bit-per-cycle multiplier. Rotate takes
// 6 products, zoom 2. A frame runs two CORDICs, then 15 products before the first
// row, then one row per accepted beat. Only one item is in flight.
// Reset clears the angles and distance and restores register defaults; the first
// item loads start_distance. A stalled receiver holds the current row steady and
// keeps item_i.ready low until the last row is taken.
module orbit_camera_view_update_unit import ocv_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  ocv_cfg_if.sink    cfg_i,
  ocv_item_if.sink   item_i,
  ocv_row_if.source  row_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PREP     = 7'b0000010,
    S_COR_GO   = 7'b0000100,
    S_COR_WAIT = 7'b0001000,
    S_MUL_GO   = 7'b0010000,
    S_MUL_WAIT = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  typedef enum logic [4:0] {
    SRC_DX, SRC_DY, SRC_DD, SRC_DT, SRC_SENS, SRC_KRAD, SRC_T,
    SRC_CX, SRC_SX, SRC_NSX, SRC_CY, SRC_SY, SRC_NSY,
    SRC_R10, SRC_R12, SRC_R20, SRC_R22, SRC_TX, SRC_TY, SRC_TZ, SRC_DIST
  } src_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_T, DST_YAW, DST_PITCH, DST_DIST,
    DST_R10, DST_R12, DST_R20, DST_R22,
    DST_TR0, DST_TR1, DST_TR2, DST_P0, DST_P1, DST_P2
  } dst_e;

  typedef struct packed {
    src_e a;
    src_e b;
    logic accum;
    dst_e dst;
    logic last;
  } uop_t;

  // configuration
  logic [UVAL_W-1:0]       sens_q, min_q, max_q, start_q;
  logic signed [VAL_W-1:0] tx_q, ty_q, tz_q;

  // control and orbit state
  state_e                  state_q, state_d;
  op_e                     op_q;
  logic [3:0]              uop_q, uop_d;
  row_e                    row_q, row_d;
  logic                    cor_sel_q, cor_sel_d;
  logic                    primed_q;
  logic [ANGLE_BITS-1:0]   yaw_q, pitch_q;
  logic signed [VAL_W-1:0] dist_q;

  // item and intermediate values
  logic signed [VAL_W-1:0] dx_q, dy_q, dd_q;
  logic [UVAL_W-1:0]       dt_q;
  logic signed [VAL_W-1:0] t_q, cx_q, sx_q, cy_q, sy_q;
  logic signed [VAL_W-1:0] r10_q, r12_q, r20_q, r22_q;
  logic signed [VAL_W-1:0] tr0_q, tr1_q, tr2_q, p0_q, p1_q, p2_q;

  logic                        item_acc, row_acc, mul_wb;
  uop_t                        uop;
  mul_cmd_t                    mul_cmd;
  logic signed [MUL_OP_W-1:0]  mul_a, mul_b;
  logic                        mul_done;
  logic signed [MUL_ACC_W-1:0] acc, neg_acc;
  logic signed [VAL_W-1:0]     mq, nq;
  logic                        cor_start, cor_done;
  logic [ANGLE_BITS-1:0]       cor_angle;
  logic signed [VAL_W-1:0]     cor_cos, cor_sin;

  assign item_acc     = item_i.valid && item_i.ready;
  assign row_acc      = row_o.valid && row_o.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign mul_wb       = (state_q == S_MUL_WAIT) && mul_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q  <= SENS_RESET;
      min_q   <= MIN_RESET;
      max_q   <= MAX_RESET;
      start_q <= START_RESET;
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SENSITIVITY: sens_q  <= cfg_i.data[UVAL_W-1:0];
        CFG_MIN_DIST:    min_q   <= cfg_i.data[UVAL_W-1:0];
        CFG_MAX_DIST:    max_q   <= cfg_i.data[UVAL_W-1:0];
        CFG_START_DIST:  start_q <= cfg_i.data[UVAL_W-1:0];
        CFG_TARGET_X:    tx_q    <= cfg_i.data;
        CFG_TARGET_Y:    ty_q    <= cfg_i.data;
        CFG_TARGET_Z:    tz_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Micro-program: one product per step.
  always_comb begin
    uop = '{SRC_T, SRC_T, 1'b0, DST_NONE, 1'b1};
    unique case (op_q)
      OP_ROTATE: begin
        unique case (uop_q)
          4'd0:    uop = '{SRC_DX, SRC_DT,   1'b0, DST_T,     1'b0};
          4'd1:    uop = '{SRC_T,  SRC_SENS, 1'b0, DST_T,     1'b0};
          4'd2:    uop = '{SRC_T,  SRC_KRAD, 1'b0, DST_YAW,   1'b0};
          4'd3:    uop = '{SRC_DY, SRC_DT,   1'b0, DST_T,     1'b0};
          4'd4:    uop = '{SRC_T,  SRC_SENS, 1'b0, DST_T,     1'b0};
          default: uop = '{SRC_T,  SRC_KRAD, 1'b0, DST_PITCH, 1'b1};
        endcase
      end
      OP_ZOOM: begin
        unique case (uop_q)
          4'd0:    uop = '{SRC_DD, SRC_DT,   1'b0, DST_T,    1'b0};
          default: uop = '{SRC_T,  SRC_SENS, 1'b0, DST_DIST, 1'b1};
        endcase
      end
      OP_FRAME: begin
        unique case (uop_q)
          4'd0:    uop = '{SRC_SY,   SRC_SX,  1'b0, DST_R10,  1'b0};
          4'd1:    uop = '{SRC_SY,   SRC_CX,  1'b0, DST_R12,  1'b0};
          4'd2:    uop = '{SRC_CY,   SRC_SX,  1'b0, DST_R20,  1'b0};
          4'd3:    uop = '{SRC_CY,   SRC_CX,  1'b0, DST_R22,  1'b0};
          4'd4:    uop = '{SRC_CX,   SRC_TX,  1'b0, DST_NONE, 1'b0};
          4'd5:    uop = '{SRC_NSX,  SRC_TZ,  1'b1, DST_TR0,  1'b0};
          4'd6:    uop = '{SRC_R10,  SRC_TX,  1'b0, DST_NONE, 1'b0};
          4'd7:    uop = '{SRC_CY,   SRC_TY,  1'b1, DST_NONE, 1'b0};
          4'd8:    uop = '{SRC_R12,  SRC_TZ,  1'b1, DST_TR1,  1'b0};
          4'd9:    uop = '{SRC_R20,  SRC_TX,  1'b0, DST_NONE, 1'b0};
          4'd10:   uop = '{SRC_NSY,  SRC_TY,  1'b1, DST_NONE, 1'b0};
          4'd11:   uop = '{SRC_R22,  SRC_TZ,  1'b1, DST_TR2,  1'b0};
          4'd12:   uop = '{SRC_DIST, SRC_R20, 1'b0, DST_P0,   1'b0};
          4'd13:   uop = '{SRC_DIST, SRC_NSY, 1'b0, DST_P1,   1'b0};
          default: uop = '{SRC_DIST, SRC_R22, 1'b0, DST_P2,   1'b1};
        endcase
      end
      default: ;
    endcase
  end

  function automatic logic signed [MUL_OP_W-1:0] operand(input src_e s);
    logic signed [MUL_OP_W-1:0] v;
    unique case (s)
      SRC_DX:   v = ocv_sext33(dx_q);
      SRC_DY:   v = ocv_sext33(dy_q);
      SRC_DD:   v = ocv_sext33(dd_q);
      SRC_DT:   v = {2'b00, dt_q};
      SRC_SENS: v = {2'b00, sens_q};
      SRC_KRAD: v = RAD_TO_TURN;
      SRC_T:    v = ocv_sext33(t_q);
      SRC_CX:   v = ocv_sext33(cx_q);
      SRC_SX:   v = ocv_sext33(sx_q);
      SRC_NSX:  v = -ocv_sext33(sx_q);
      SRC_CY:   v = ocv_sext33(cy_q);
      SRC_SY:   v = ocv_sext33(sy_q);
      SRC_NSY:  v = -ocv_sext33(sy_q);
      SRC_R10:  v = ocv_sext33(r10_q);
      SRC_R12:  v = ocv_sext33(r12_q);
      SRC_R20:  v = ocv_sext33(r20_q);
      SRC_R22:  v = ocv_sext33(r22_q);
      SRC_TX:   v = ocv_sext33(tx_q);
      SRC_TY:   v = ocv_sext33(ty_q);
      SRC_TZ:   v = ocv_sext33(tz_q);
      SRC_DIST: v = ocv_sext33(dist_q);
      default:  v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    mul_a         = operand(uop.a);
    mul_b         = operand(uop.b);
    mul_cmd.start = (state_q == S_MUL_GO);
    mul_cmd.accum = uop.accum;
  end

  ocv_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .acc_o  (acc)
  );

  assign cor_start = (state_q == S_COR_GO);
  assign cor_angle = cor_sel_q ? pitch_q : yaw_q;

  ocv_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  assign neg_acc = -acc;
  assign mq      = ocv_sat_wide(acc >>> 16);
  assign nq      = ocv_sat_wide(neg_acc >>> 16);

  always_comb begin
    state_d   = state_q;
    uop_d     = uop_q;
    row_d     = row_q;
    cor_sel_d = cor_sel_q;
    unique case (state_q)
      S_IDLE: if (item_acc) state_d = S_PREP;
      S_PREP: begin
        uop_d     = '0;
        row_d     = ROW_COL0;
        cor_sel_d = 1'b0;
        unique case (op_q)
          OP_ROTATE, OP_ZOOM: state_d = S_MUL_GO;
          OP_FRAME:           state_d = S_COR_GO;
          default:            state_d = S_IDLE;
        endcase
      end
      S_COR_GO: state_d = S_COR_WAIT;
      S_COR_WAIT: begin
        if (cor_done) begin
          if (cor_sel_q) begin
            state_d = S_MUL_GO;
          end else begin
            cor_sel_d = 1'b1;
            state_d   = S_COR_GO;
          end
        end
      end
      S_MUL_GO: state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          if (uop.last) begin
            state_d = (op_q == OP_FRAME) ? S_OUT : S_IDLE;
          end else begin
            uop_d   = uop_q + 4'd1;
            state_d = S_MUL_GO;
          end
        end
      end
      S_OUT: begin
        if (row_acc) begin
          if (row_q == ROW_POS) state_d = S_IDLE;
          else row_d = row_e'(row_q + 3'd1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_NONE;
      uop_q     <= '0;
      row_q     <= ROW_COL0;
      cor_sel_q <= 1'b0;
      primed_q  <= 1'b0;
      yaw_q     <= '0;
      pitch_q   <= '0;
      dist_q    <= '0;
    end else begin
      state_q   <= state_d;
      uop_q     <= uop_d;
      row_q     <= row_d;
      cor_sel_q <= cor_sel_d;
      if (item_acc) op_q <= op_e'(item_i.operation);
      if (state_q == S_PREP) begin
        // load the start distance once, then clamp on every item
        dist_q   <= ocv_clamp(primed_q ? dist_q : {1'b0, start_q}, min_q, max_q);
        primed_q <= 1'b1;
      end
      if (mul_wb) begin
        unique case (uop.dst)
          DST_YAW:   yaw_q   <= yaw_q + acc[ANGLE_FRAC_TOP -: ANGLE_BITS];
          DST_PITCH: pitch_q <= pitch_q + acc[ANGLE_FRAC_TOP -: ANGLE_BITS];
          DST_DIST:  dist_q  <= ocv_clamp(ocv_sat33(ocv_sext33(dist_q) + ocv_sext33(mq)),
                                          min_q, max_q);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      dx_q <= item_i.delta_x;
      dy_q <= item_i.delta_y;
      dd_q <= item_i.delta_distance;
      dt_q <= item_i.time_step;
    end
    if (cor_done) begin
      if (cor_sel_q) begin
        cy_q <= cor_cos;
        sy_q <= cor_sin;
      end else begin
        cx_q <= cor_cos;
        sx_q <= cor_sin;
      end
    end
    if (mul_wb) begin
      unique case (uop.dst)
        DST_T:   t_q   <= mq;
        DST_R10: r10_q <= mq;
        DST_R12: r12_q <= mq;
        DST_R20: r20_q <= mq;
        DST_R22: r22_q <= mq;
        DST_TR0: tr0_q <= nq;
        DST_TR1: tr1_q <= nq;
        DST_TR2: tr2_q <= ocv_sat33(ocv_sext33(nq) - ocv_sext33(dist_q));
        DST_P0:  p0_q  <= ocv_sat33(ocv_sext33(tx_q) + ocv_sext33(mq));
        DST_P1:  p1_q  <= ocv_sat33(ocv_sext33(ty_q) + ocv_sext33(mq));
        DST_P2:  p2_q  <= ocv_sat33(ocv_sext33(tz_q) + ocv_sext33(mq));
        default: ;
      endcase
    end
  end

  always_comb begin
    row_o.valid     = (state_q == S_OUT);
    row_o.row_index = row_q;
    row_o.last_row  = (row_q == ROW_POS);
    unique case (row_q)
      ROW_COL0: begin
        row_o.value_0 = cx_q;
        row_o.value_1 = r10_q;
        row_o.value_2 = r20_q;
        row_o.value_3 = '0;
      end
      ROW_COL1: begin
        row_o.value_0 = '0;
        row_o.value_1 = cy_q;
        row_o.value_2 = -sy_q;
        row_o.value_3 = '0;
      end
      ROW_COL2: begin
        row_o.value_0 = -sx_q;
        row_o.value_1 = r12_q;
        row_o.value_2 = r22_q;
        row_o.value_3 = '0;
      end
      ROW_COL3: begin
        row_o.value_0 = tr0_q;
        row_o.value_1 = tr1_q;
        row_o.value_2 = tr2_q;
        row_o.value_3 = ONE_Q16;
      end
      default: begin
        row_o.value_0 = p0_q;
        row_o.value_1 = p1_q;
        row_o.value_2 = p2_q;
        row_o.value_3 = '0;
      end
    endcase
  end

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_acc |=> state_q == S_PREP)
    else $error("accepted item did not enter preparation");
  a_dist_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PREP |=> dist_q >= $signed({1'b0, $past(min_q)}))
    else $error("distance below lower bound after clamp");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_acc && row_o.last_row |=> item_i.ready)
    else $error("unit not idle after last row");

endmodule

[sim/tb_orbit_camera_view_update_unit.sv]
// Self-checking bench for the orbit camera view unit: random rotate, zoom and frame beats
// against an in-bench view matrix predictor. Depends on ocv_pkg, ocv_if and the unit RTL.
`timescale 1ns / 100ps

module tb_orbit_camera_view_update_unit;
  import ocv_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 700;

  typedef struct {
    op_e                     op;
    logic signed [VAL_W-1:0] dx;
    logic signed [VAL_W-1:0] dy;
    logic signed [VAL_W-1:0] dd;
    logic [UVAL_W-1:0]       dt;
  } cam_item_t;

  typedef struct {
    logic [ROW_W-1:0]        idx;
    logic signed [VAL_W-1:0] v0, v1, v2, v3;
    logic                    last;
  } view_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ocv_cfg_if  cfg_ch ();
  ocv_item_if item_ch ();
  ocv_row_if  row_ch ();

  orbit_camera_view_update_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .item_i (item_ch.sink),
    .row_o  (row_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  longint p_sens, p_min, p_max, p_start, p_tx, p_ty, p_tz;
  longint p_dist;
  logic [15:0] p_yaw, p_pitch;
  bit p_primed;

  cam_item_t pending_items[$];
  view_row_t expected_rows[$];
  int mismatches = 0;
  int rows_seen = 0;
  int frames_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit item_taken = 1'b0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic logic [15:0] turn_step(longint delta, longint dt);
    longint rad, units;
    rad = qmul(qmul(delta, dt), p_sens);
    units = (rad * 64'sd683565276) >>> 32;
    return units[15:0];
  endfunction

  function automatic void sin_cos(logic [15:0] ang, output longint c, output longint s);
    logic [31:0] t;
    bit flip;
    longint x, y, z, nx, ny;
    t = {ang, 16'h0};
    flip = ((t + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) t = t + 32'h8000_0000;
    z = longint'($signed(t));
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - longint'(ocv_atan(i[4:0]));
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + longint'(ocv_atan(i[4:0]));
      end
      x = nx; y = ny;
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic void clamp_dist();
    longint hi;
    hi = (p_max < p_min) ? p_min : p_max;
    if (p_dist < p_min) p_dist = p_min;
    else if (p_dist > hi) p_dist = hi;
  endfunction

  function automatic void push_row(int k, longint a, longint b, longint c, longint d,
                                   bit last);
    view_row_t r;
    r.idx = k[2:0]; r.v0 = a[31:0]; r.v1 = b[31:0]; r.v2 = c[31:0]; r.v3 = d[31:0];
    r.last = last;
    expected_rows.push_back(r);
  endfunction

  function automatic void predict_view(cam_item_t it);
    longint cx, sx, cy, sy, d, acc;
    longint r[3][3];
    longint tg[3], tr[3];
    if (!p_primed) begin
      p_dist = p_start; p_primed = 1'b1;
    end
    clamp_dist();
    case (it.op)
      OP_ROTATE: begin
        p_yaw = p_yaw + turn_step(longint'(it.dx), longint'(it.dt));
        p_pitch = p_pitch + turn_step(longint'(it.dy), longint'(it.dt));
      end
      OP_ZOOM: begin
        p_dist = sat32(p_dist + qmul(qmul(longint'(it.dd), longint'(it.dt)), p_sens));
        clamp_dist();
      end
      OP_FRAME: begin
        d = p_dist;
        sin_cos(p_yaw, cx, sx);
        sin_cos(p_pitch, cy, sy);
        r[0][0] = cx; r[0][1] = 0; r[0][2] = -sx;
        r[1][0] = qmul(sy, sx); r[1][1] = cy; r[1][2] = qmul(sy, cx);
        r[2][0] = qmul(cy, sx); r[2][1] = -sy; r[2][2] = qmul(cy, cx);
        tg[0] = p_tx; tg[1] = p_ty; tg[2] = p_tz;
        for (int i = 0; i < 3; i++) begin
          acc = r[i][0] * tg[0] + r[i][1] * tg[1] + r[i][2] * tg[2];
          tr[i] = sat32((-acc) >>> 16);
        end
        tr[2] = sat32(tr[2] - d);
        for (int i = 0; i < 3; i++) push_row(i, r[0][i], r[1][i], r[2][i], 0, 1'b0);
        push_row(3, tr[0], tr[1], tr[2], 65536, 1'b0);
        push_row(4, sat32(tg[0] + qmul(d, r[2][0])), sat32(tg[1] + qmul(d, r[2][1])),
                 sat32(tg[2] + qmul(d, r[2][2])), 0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // driver: bursts with random gaps; hold a beat until it has been taken
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_ch.valid <= 1'b0;
    end else if (item_ch.valid && !item_taken) begin
      // hold the beat
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      item_ch.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      cam_item_t it;
      it = pending_items.pop_front();
      item_ch.valid <= 1'b1;
      item_ch.operation <= it.op;
      item_ch.delta_x <= it.dx;
      item_ch.delta_y <= it.dy;
      item_ch.delta_distance <= it.dd;
      item_ch.time_step <= it.dt;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 6);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      item_ch.valid <= 1'b0;
    end
  end

  // predict on the accepted beat
  always @(posedge clk_i) begin
    item_taken <= rst_ni && item_ch.valid && item_ch.ready;
    if (rst_ni && item_ch.valid && item_ch.ready) begin
      cam_item_t it;
      it.op = op_e'(item_ch.operation);
      it.dx = item_ch.delta_x; it.dy = item_ch.delta_y;
      it.dd = item_ch.delta_distance; it.dt = item_ch.time_step;
      predict_view(it);
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (!rst_ni || hold_off) row_ch.ready <= 1'b0;
    else if (stall_phase[9]) row_ch.ready <= 1'b1;
    else row_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && row_ch.valid && row_ch.ready) begin
      view_row_t e;
      rows_seen <= rows_seen + 1;
      if (expected_rows.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected row beat, index %0d", row_ch.row_index);
      end else begin
        e = expected_rows.pop_front();
        if (row_ch.row_index !== e.idx || row_ch.value_0 !== e.v0 ||
            row_ch.value_1 !== e.v1 || row_ch.value_2 !== e.v2 ||
            row_ch.value_3 !== e.v3 || row_ch.last_row !== e.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("row mismatch: exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
                     e.idx, e.v0, e.v1, e.v2, e.v3, e.last, row_ch.row_index,
                     row_ch.value_0, row_ch.value_1, row_ch.value_2, row_ch.value_3,
                     row_ch.last_row);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((item_ch.valid && item_ch.ready) || (row_ch.valid && row_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_SENSITIVITY: p_sens = longint'(val[30:0]);
      CFG_MIN_DIST:    p_min = longint'(val[30:0]);
      CFG_MAX_DIST:    p_max = longint'(val[30:0]);
      CFG_START_DIST:  p_start = longint'(val[30:0]);
      CFG_TARGET_X:    p_tx = longint'($signed(val));
      CFG_TARGET_Y:    p_ty = longint'($signed(val));
      CFG_TARGET_Z:    p_tz = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_item(op_e op, logic [31:0] dx, logic [31:0] dy, logic [31:0] dd,
                            logic [30:0] dt);
    cam_item_t it;
    it.op = op; it.dx = dx; it.dy = dy; it.dd = dd; it.dt = dt;
    pending_items.push_back(it);
    if (op == OP_FRAME) frames_sent++;
  endtask

  // wait until every item is taken and every row has come, then let the unit settle
  task automatic drain();
    while (pending_items.size() > 0 || item_ch.valid) @(posedge clk_i);
    while (expected_rows.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_small_rate();
    return $urandom_range(0, 1) ? $urandom_range(0, 32'h0003_0000)
                                : -$urandom_range(0, 32'h0003_0000);
  endfunction

  task automatic random_phase(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8)
        queue_item(OP_ROTATE, rand_small_rate(), rand_small_rate(), $urandom(),
                   $urandom_range(0, 32'h0002_0000));
      else if (pick < 12)
        queue_item(OP_ZOOM, $urandom(), $urandom(), rand_small_rate(),
                   $urandom_range(0, 32'h0002_0000));
      else if (pick < 18)
        queue_item(OP_FRAME, $urandom(), $urandom(), $urandom(), $urandom());
      else if (pick == 18)
        queue_item(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom());
      else
        queue_item(op_e'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom(),
                   $urandom());
    end
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    item_ch.valid = 1'b0; item_ch.operation = '0; item_ch.delta_x = '0;
    item_ch.delta_y = '0; item_ch.delta_distance = '0; item_ch.time_step = '0;
    row_ch.ready = 1'b0;
    p_sens = 65536; p_min = 0; p_max = 655360; p_start = 327680;
    p_tx = 0; p_ty = 0; p_tz = 0; p_dist = 0; p_yaw = '0; p_pitch = '0; p_primed = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first item primes from the start distance, then extremes
    write_reg(CFG_START_DIST, 32'h0003_0000);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ROTATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ROTATE, 32'h0001_0000, 32'hFFFF_0000, 0, 31'h0001_0000);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ZOOM, 0, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_item(OP_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    queue_item(OP_ZOOM, 0, 0, 32'h8000_0000, 31'h7FFF_FFFF);
    queue_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ROTATE, 32'h0000_4000, 32'h0000_8000, 0, 31'h0001_0000);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    drain();

    // extreme registers: max below min, big targets, zero and full gain
    write_reg(CFG_START_DIST, 32'h7FFF_FFFF);
    write_reg(CFG_MIN_DIST, 32'h0004_0000);
    write_reg(CFG_MAX_DIST, 32'h0001_0000);
    write_reg(CFG_TARGET_X, 32'h7FFF_FFFF);
    write_reg(CFG_TARGET_Y, 32'h8000_0000);
    write_reg(CFG_TARGET_Z, 32'h7FFF_FFFF);
    write_reg(CFG_SENSITIVITY, 32'h7FFF_FFFF);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ROTATE, 32'h0000_1000, 32'h0000_3000, 0, 31'h0000_0100);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    queue_item(OP_ZOOM, 0, 0, 32'h0000_0001, 31'h0000_0001);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    drain();

    write_reg(CFG_SENSITIVITY, 32'h0000_0000);
    write_reg(CFG_MIN_DIST, 32'h0000_0000);
    write_reg(CFG_MAX_DIST, 32'h7FFF_FFFF);
    queue_item(OP_ROTATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
    queue_item(OP_FRAME, 0, 0, 0, 0);
    drain();

    // random phases under ordinary settings
    write_reg(CFG_SENSITIVITY, 32'h0001_0000);
    write_reg(CFG_MIN_DIST, 32'h0000_8000);
    write_reg(CFG_MAX_DIST, 32'h0014_0000);
    write_reg(CFG_TARGET_X, 32'h0002_8000);
    write_reg(CFG_TARGET_Y, 32'hFFFE_0000);
    write_reg(CFG_TARGET_Z, 32'h0000_4000);
    random_phase(100);
    drain();

    write_reg(CFG_SENSITIVITY, $urandom_range(0, 32'h0004_0000));
    write_reg(CFG_MIN_DIST, $urandom_range(0, 32'h0010_0000));
    write_reg(CFG_MAX_DIST, $urandom_range(0, 32'h0040_0000));
    write_reg(CFG_TARGET_X, $urandom());
    write_reg(CFG_TARGET_Y, $urandom());
    write_reg(CFG_TARGET_Z, $urandom());
    // hold the receiver off while frames queue up behind the stalled unit
    hold_off = 1'b1;
    random_phase(100);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b0;
    drain();

    write_reg(CFG_SENSITIVITY, $urandom_range(0, 32'h7FFF_FFFF));
    write_reg(CFG_MIN_DIST, 32'h7FFF_FFFF);
    random_phase(80);
    drain();

    $display("covered %0d frames, %0d rows checked, across six register settings",
             frames_sent, rows_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
